@@ rtl/core/radix_integer_parser_defines.svh @@
`ifndef RADIX_INTEGER_PARSER_DEFINES_SVH
`define RADIX_INTEGER_PARSER_DEFINES_SVH

// same-cycle implication, reset disables the check
`define RIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radix parser check failed");

// next-cycle implication, reset disables the check
`define RIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radix parser check failed");

`endif

@@ rtl/core/rip_pkg.sv @@
package rip_pkg;

    localparam int VALUE_W  = 64;
    localparam int RADIX_W  = 5;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;
    localparam int PROD_W   = VALUE_W + RADIX_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NODIGITS = 2'd2;

    localparam logic CFG_MAX_VALUE = 1'b0;
    localparam logic CFG_RADIX     = 1'b1;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = '1;
    localparam logic [RADIX_W-1:0] RADIX_RESET     = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN       = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX       = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_SAT       = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] max_value;
        logic [RADIX_W-1:0] radix;
    } t_cfg;

    typedef struct packed {
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } t_class;

    // ascii 0-9, A-F, a-f to digit value
    function automatic t_class char_to_digit(input logic [CHAR_W-1:0] ch);
        t_class c;
        c.is_digit = 1'b1;
        c.digit    = '0;
        case (ch) inside
            [8'h30:8'h39]: c.digit = DIGIT_W'(ch - 8'h30);
            [8'h41:8'h46]: c.digit = DIGIT_W'(ch - 8'h37);
            [8'h61:8'h66]: c.digit = DIGIT_W'(ch - 8'h57);
            default: begin
                c.is_digit = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/radix_integer_parser.sv @@
// the request that ends a number passes the input register, then its result is registered in the result register
// throughput: one character per cycle, sustained while results are taken
// the input register and the result register are the two stages; the
// accumulator recurrence closes through a 64x5 multiply-add into the accumulator register
// reset: synchronous active low, clears the parse state and both stages,
// sets max_value to all ones and radix to 10
`include "radix_integer_parser_defines.svh"

module radix_integer_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [rip_pkg::VALUE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rip_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                         i_start_req,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rip_pkg::VALUE_W-1:0]  o_value,
    output logic [rip_pkg::STATUS_W-1:0] o_status,
    output logic [rip_pkg::COUNT_W-1:0]  o_digit_count
);

    logic                        r_in_valid;
    logic [rip_pkg::CHAR_W-1:0]  r_in_char;
    logic                        r_in_start;
    logic                        w_advance;
    logic                        w_fire;
    rip_pkg::t_cfg               w_cfg;
    rip_pkg::t_class             w_class;

    // the input stage moves on whenever the result register can take a result
    assign w_advance  = !o_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char  <= i_char_code;
            r_in_start <= i_start_req;
        end
    end

    rip_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rip_char_class u_class (
        .i_char  (r_in_char),
        .i_radix (w_cfg.radix),
        .o_class (w_class)
    );

    rip_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_start       (r_in_start),
        .i_class       (w_class),
        .i_cfg         (w_cfg),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_digit_count (o_digit_count)
    );

    `RIP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_in_char) && $stable(r_in_start))
    `RIP_ASSERT_NEXT(a_result_from_request, i_clk, i_rst_n, !o_out_valid && !r_in_valid, !o_out_valid)
    `RIP_ASSERT_NOW(a_error_zero, i_clk, i_rst_n, o_out_valid && (o_status != rip_pkg::ST_OK), (o_value == '0) && (o_status <= rip_pkg::ST_NODIGITS))

endmodule

@@ rtl/core/rip_cfg_regs.sv @@
module rip_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [rip_pkg::VALUE_W-1:0] i_cfg_data,
    output rip_pkg::t_cfg               o_cfg
);

    logic [rip_pkg::VALUE_W-1:0] r_max_value;
    logic [rip_pkg::RADIX_W-1:0] r_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= rip_pkg::MAX_VALUE_RESET;
            r_radix     <= rip_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rip_pkg::CFG_MAX_VALUE) begin
                r_max_value <= i_cfg_data;
            end else begin
                r_radix <= i_cfg_data[rip_pkg::RADIX_W-1:0];
            end
        end
    end

    // clamp radix into 2..16
    always_comb begin
        o_cfg.max_value = r_max_value;
        if (r_radix < rip_pkg::RADIX_MIN) begin
            o_cfg.radix = rip_pkg::RADIX_MIN;
        end else if (r_radix > rip_pkg::RADIX_MAX) begin
            o_cfg.radix = rip_pkg::RADIX_MAX;
        end else begin
            o_cfg.radix = r_radix;
        end
    end

endmodule

@@ rtl/core/rip_char_class.sv @@
module rip_char_class (
    input  logic [rip_pkg::CHAR_W-1:0]  i_char,
    input  logic [rip_pkg::RADIX_W-1:0] i_radix,
    output rip_pkg::t_class             o_class
);

    rip_pkg::t_class w_raw;

    always_comb begin
        w_raw            = rip_pkg::char_to_digit(i_char);
        o_class.digit    = w_raw.digit;
        o_class.is_digit = w_raw.is_digit
                           && (rip_pkg::RADIX_W'(w_raw.digit) < i_radix);
    end

endmodule

@@ rtl/core/rip_accum.sv @@
module rip_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_start,
    input  rip_pkg::t_class              i_class,
    input  rip_pkg::t_cfg                i_cfg,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [rip_pkg::VALUE_W-1:0]  o_value,
    output logic [rip_pkg::STATUS_W-1:0] o_status,
    output logic [rip_pkg::COUNT_W-1:0]  o_digit_count
);

    logic                         r_active;
    logic                         n_active;
    logic [rip_pkg::VALUE_W-1:0]  r_acc;
    logic [rip_pkg::VALUE_W-1:0]  n_acc;
    logic [rip_pkg::COUNT_W-1:0]  r_cnt;
    logic [rip_pkg::COUNT_W-1:0]  n_cnt;
    logic                         r_out_valid;
    logic [rip_pkg::VALUE_W-1:0]  r_value;
    logic [rip_pkg::STATUS_W-1:0] r_status;
    logic [rip_pkg::COUNT_W-1:0]  r_count;

    logic                         w_active;
    logic [rip_pkg::VALUE_W-1:0]  w_acc;
    logic [rip_pkg::COUNT_W-1:0]  w_cnt;
    logic [rip_pkg::PROD_W-1:0]   w_prod;
    logic [rip_pkg::SUM_W-1:0]    w_sum;
    logic                         w_ovf;
    logic                         w_emit;
    logic [rip_pkg::VALUE_W-1:0]  w_value;
    logic [rip_pkg::STATUS_W-1:0] w_status;

    always_comb begin
        w_active = i_start || r_active;
        w_acc    = i_start ? '0 : r_acc;
        w_cnt    = i_start ? '0 : r_cnt;
        // acc*radix + digit against max covers both overflow checks exactly
        w_prod   = rip_pkg::PROD_W'(w_acc) * rip_pkg::PROD_W'(i_cfg.radix);
        w_sum    = rip_pkg::SUM_W'(w_prod) + rip_pkg::SUM_W'(i_class.digit);
        w_ovf    = w_sum > rip_pkg::SUM_W'(i_cfg.max_value);

        n_active = r_active;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        w_emit   = 1'b0;
        w_value  = '0;
        w_status = rip_pkg::ST_OK;
        if (i_fire && w_active) begin
            n_acc = w_acc;
            n_cnt = w_cnt;
            if (!i_class.is_digit) begin
                w_emit   = 1'b1;
                n_active = 1'b0;
                if (w_cnt == '0) begin
                    w_status = rip_pkg::ST_NODIGITS;
                end else begin
                    w_value = w_acc;
                end
            end else if (w_ovf) begin
                w_emit   = 1'b1;
                n_active = 1'b0;
                w_status = rip_pkg::ST_OVERFLOW;
            end else begin
                n_active = 1'b1;
                n_acc    = w_sum[rip_pkg::VALUE_W-1:0];
                if (w_cnt != rip_pkg::COUNT_SAT) begin
                    n_cnt = w_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_value  <= w_value;
            r_status <= w_status;
            r_count  <= w_cnt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_status      = r_status;
    assign o_digit_count = r_count;

endmodule

@@ bench/parse_result_checker.sv @@
module parse_result_checker
    import rip_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [VALUE_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic                i_start_req,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [COUNT_W-1:0]  i_digit_count,
    output int                  o_mismatches,
    output int                  o_pending
);

    localparam logic [DIGIT_W:0] NOT_A_DIGIT = '1;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } parse_result_t;

    parse_result_t      expected_results[$];
    logic [VALUE_W-1:0] limit_value = MAX_VALUE_RESET;
    logic [RADIX_W-1:0] radix_reg   = RADIX_RESET;
    logic [VALUE_W-1:0] accum       = '0;
    logic               in_number   = 1'b0;
    logic [COUNT_W-1:0] digits_taken = '0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [DIGIT_W:0] digit_value(input logic [CHAR_W-1:0] ch);
        if (ch >= "0" && ch <= "9") return (DIGIT_W+1)'(ch - "0");
        if (ch >= "A" && ch <= "F") return (DIGIT_W+1)'(ch - "A" + 8'd10);
        if (ch >= "a" && ch <= "f") return (DIGIT_W+1)'(ch - "a" + 8'd10);
        return NOT_A_DIGIT;
    endfunction

    function automatic logic [RADIX_W-1:0] base_in_use();
        if (radix_reg < RADIX_MIN) return RADIX_MIN;
        if (radix_reg > RADIX_MAX) return RADIX_MAX;
        return radix_reg;
    endfunction

    task automatic emit(input logic [VALUE_W-1:0] v, input logic [STATUS_W-1:0] s,
                        input logic [COUNT_W-1:0] c);
        parse_result_t r;
        r.value  = v;
        r.status = s;
        r.count  = c;
        expected_results.push_back(r);
        in_number = 1'b0;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic first);
        logic [RADIX_W-1:0] b;
        logic [DIGIT_W:0]   d;
        logic [SUM_W-1:0]   grown;
        b = base_in_use();
        d = digit_value(ch);
        if (first) begin
            in_number    = 1'b1;
            accum        = '0;
            digits_taken = '0;
        end
        if (!in_number) return;
        if (d == NOT_A_DIGIT || d >= b) begin
            if (digits_taken == '0) emit('0, ST_NODIGITS, '0);
            else emit(accum, ST_OK, digits_taken);
            return;
        end
        grown = SUM_W'(accum) * SUM_W'(b) + SUM_W'(d);
        if (grown > SUM_W'(limit_value)) begin
            emit('0, ST_OVERFLOW, digits_taken);
            return;
        end
        accum = grown[VALUE_W-1:0];
        if (digits_taken != COUNT_SAT) digits_taken++;
    endtask

    task automatic check_result();
        parse_result_t want;
        if (expected_results.size() == 0) begin
            $error("result with no request pending: value %0h status %0d count %0d",
                   i_value, i_status, i_digit_count);
            o_mismatches++;
            return;
        end
        want = expected_results.pop_front();
        if (i_value !== want.value) begin
            $error("value: expected %0h, actual %0h", want.value, i_value);
            o_mismatches++;
        end
        if (i_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, i_status);
            o_mismatches++;
        end
        if (i_digit_count !== want.count) begin
            $error("digit_count: expected %0d, actual %0d", want.count, i_digit_count);
            o_mismatches++;
        end
    endtask

    // inputs move only on rising edges, so the falling edge sees what the next edge takes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            limit_value  = MAX_VALUE_RESET;
            radix_reg    = RADIX_RESET;
            accum        = '0;
            in_number    = 1'b0;
            digits_taken = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_VALUE) limit_value = i_cfg_data;
                else radix_reg = i_cfg_data[RADIX_W-1:0];
            end
            if (i_in_valid && i_in_ready) parse_char(i_char_code, i_start_req);
        end
        o_pending = expected_results.size();
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    import rip_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SLOTS         = 6;
    localparam int SLOT_CHARS    = 51;
    localparam int MAX_GAP       = 40;
    localparam int SEND_IDLE [3] = '{29, 86, 0};
    localparam int RECV_IDLE [3] = '{86, 29, 0};
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] MARKS [10] =
        '{8'h00, 8'h20, 8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h7F, 8'hFF};

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic                cfg_index   = CFG_MAX_VALUE;
    logic [VALUE_W-1:0]  cfg_data    = '0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [CHAR_W-1:0]   char_code   = '0;
    logic                start_req   = 1'b0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  digit_count;

    int mismatches;
    int pending;
    int cycles        = 0;
    int send_idle_pct = SEND_IDLE[0];
    int recv_idle_pct = RECV_IDLE[0];
    int base          = 10;
    int parse_chars   = 0;

    radix_integer_parser dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_char_code   (char_code),
        .i_start_req   (start_req),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_value       (value),
        .o_status      (status),
        .o_digit_count (digit_count)
    );

    parse_result_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_char_code   (char_code),
        .i_start_req   (start_req),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_value       (value),
        .i_status      (status),
        .i_digit_count (digit_count),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic first);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < MAX_GAP) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        start_req <= first;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [VALUE_W-1:0] limit,
                              input logic [VALUE_W-1:0] radix_word);
        logic [RADIX_W-1:0] r;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_VALUE;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= CFG_RADIX;
        cfg_data  <= radix_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        r = radix_word[RADIX_W-1:0];
        base = int'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
    endtask

    task automatic random_config();
        logic [VALUE_W-1:0] limit;
        logic [VALUE_W-1:0] radix_word;
        case ($urandom_range(7))
            0: limit = '0;
            1: limit = {$urandom, $urandom};
            2: limit = VALUE_W'($urandom_range(65535));
            3: limit = {VALUE_W{1'b1}} >> $urandom_range(63);
            4: limit = {$urandom, $urandom} >> $urandom_range(63);
            default: limit = '1;
        endcase
        case ($urandom_range(9))
            0: radix_word = VALUE_W'(RADIX_MIN);
            1: radix_word = VALUE_W'(RADIX_MAX);
            2: radix_word = VALUE_W'($urandom_range(1, 0));
            3: radix_word = VALUE_W'($urandom_range(31, 17));
            default: radix_word = VALUE_W'($urandom_range(16, 2));
        endcase
        // junk above the radix field
        if ($urandom_range(3) == 0) radix_word |= {$urandom, $urandom} & ~64'h1F;
        set_config(limit, radix_word);
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return CH_ZERO + 8'(d);
        if ($urandom_range(1) == 1) return CH_UPPER_A + 8'(d - 10);
        return CH_LOWER_A + 8'(d - 10);
    endfunction

    function automatic logic [7:0] random_digit();
        if ($urandom_range(3) == 0) return digit_char(base - 1);
        return digit_char($urandom_range(base - 1, 0));
    endfunction

    function automatic logic [7:0] non_digit();
        case ($urandom_range(4))
            0: return MARKS[$urandom_range(9)];
            1: return 8'($urandom_range(255, 128));
            2: return (base < 16) ? digit_char($urandom_range(15, base))
                                  : MARKS[$urandom_range(9)];
            3: return 8'($urandom_range(8'h7A, 8'h67));
            default: return 8'($urandom_range(8'h5A, 8'h47));
        endcase
    endfunction

    task automatic send_number();
        int len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) len = $urandom_range(5, 1);
        else if (pick < 85) len = $urandom_range(20, 6);
        else len = $urandom_range(70, 21);
        if ($urandom_range(9) == 0) begin
            send_char(non_digit(), 1'b1);
            parse_chars++;
            return;
        end
        send_char(random_digit(), 1'b1);
        repeat (len - 1) send_char(random_digit(), 1'b0);
        parse_chars += len;
        // sometimes no terminator: the next start drops the number
        if ($urandom_range(4) != 0) begin
            send_char(non_digit(), 1'b0);
            parse_chars++;
        end
    endtask

    // more than 255 digits so the count saturates
    task automatic send_long();
        int zeros;
        int tail;
        zeros = $urandom_range(262, 256);
        tail  = $urandom_range(4, 1);
        send_char(CH_ZERO, 1'b1);
        repeat (zeros) send_char(CH_ZERO, 1'b0);
        repeat (tail) send_char(random_digit(), 1'b0);
        send_char(non_digit(), 1'b0);
        parse_chars += zeros + tail + 2;
    endtask

    initial begin
        int slot_end;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_char("9", 1'b1);
        send_char("a", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char("z", 1'b0);
        send_char("1", 1'b1);
        send_char("2", 1'b0);
        send_char("3", 1'b1);
        send_char(8'h80, 1'b0);
        wait_for_results();
        set_config(64'hFF, 64'd16);
        send_char("f", 1'b1);
        send_char("F", 1'b0);
        send_char("g", 1'b0);
        send_char("1", 1'b1);
        send_char("0", 1'b0);
        send_char("0", 1'b0);
        send_char("0", 1'b0);
        wait_for_results();
        set_config('0, 64'd2);
        send_char("1", 1'b1);
        send_char("0", 1'b1);
        send_char("0", 1'b0);
        send_char("2", 1'b0);
        wait_for_results();
        set_config(64'd5, 64'd31);
        send_char("F", 1'b1);
        wait_for_results();
        set_config(64'd5, 64'd0);
        send_char("1", 1'b1);
        send_char(" ", 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            for (int slot = 0; slot < SLOTS; slot++) begin
                wait_for_results();
                if (slot == 0) set_config('1, (phase == 0) ? 64'd16 : 64'd2);
                else random_config();
                if (slot == 0 && phase != 1) send_long();
                slot_end = parse_chars + SLOT_CHARS;
                while (parse_chars < slot_end) begin
                    if ($urandom_range(11) == 0)
                        repeat ($urandom_range(3, 1)) send_char(8'($urandom_range(255)), 1'b0);
                    send_number();
                    if ($urandom_range(49) == 0) wait_for_results();
                end
            end
        end

        wait_for_results();
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ radix_integer_parser.f @@
+incdir+rtl/core
rtl/core/rip_pkg.sv
rtl/core/rip_cfg_regs.sv
rtl/core/rip_char_class.sv
rtl/core/rip_accum.sv
rtl/core/radix_integer_parser.sv
bench/parse_result_checker.sv
bench/testbench.sv
